### src/bsa_pkg.sv
// Shared constants, operation codes and the default request record for the step adjuster.
`timescale 1ns / 1ps

package bsa_pkg;

  // Default brightness value width.
  localparam int VALUE_BITS_DEF = 20;
  // Width of the step count register.
  localparam int STEP_BITS = 7;
  // Depth of the queue between the classifier and the arithmetic pipeline.
  localparam int QUEUE_DEPTH = 4;

  // Percent scale and the doubled divisor used for rounding half up.
  localparam int PCT_SCALE = 100;
  localparam int PCT_SCALE_X2 = 2 * PCT_SCALE;

  // Configuration register indexes.
  localparam logic [1:0] REG_VALUE_MIN = 2'd0;
  localparam logic [1:0] REG_VALUE_MAX = 2'd1;
  localparam logic [1:0] REG_STEP_COUNT = 2'd2;

  typedef enum logic [1:0] {
    OP_INC      = 2'd0,
    OP_DEC      = 2'd1,
    OP_INC_FINE = 2'd2,
    OP_DEC_FINE = 2'd3
  } op_t;

  // Classified request at the default width; the top level rebuilds it for its own width.
  typedef struct packed {
    op_t                         op;
    logic [VALUE_BITS_DEF-1:0]   cur;
    logic                        early;
    logic [VALUE_BITS_DEF-1:0]   early_val;
    logic                        a_neg;
    logic [VALUE_BITS_DEF+7:0]   a_prod;
  } item_t;

endpackage

### src/bsa_divpipe.sv
// Pipelined restoring divider, one quotient bit per stage, several lanes sharing one sideband.
`timescale 1ns / 1ps

module bsa_divpipe #(
  parameter int  NUM_W = 28,
  parameter int  DEN_W = 21,
  parameter int  LANES = 1,
  parameter type side_t = logic
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic [LANES-1:0][NUM_W-1:0]  num,
  input  logic [LANES-1:0][DEN_W-1:0]  den,
  input  side_t                        side_in,
  output logic                         out_valid,
  output logic [LANES-1:0][NUM_W-1:0]  quo,
  output side_t                        side_out
);

  logic                         valid_r [NUM_W];
  side_t                        side_r  [NUM_W];
  logic [LANES-1:0][NUM_W-1:0]  num_r   [NUM_W];
  logic [LANES-1:0][NUM_W-1:0]  quo_r   [NUM_W];
  logic [LANES-1:0][DEN_W-1:0]  rem_r   [NUM_W];

  logic [LANES-1:0][NUM_W-1:0]  quo_next [NUM_W];
  logic [LANES-1:0][DEN_W-1:0]  rem_next [NUM_W];

  // Each stage brings down one numerator bit and tries one subtraction.
  always_comb begin
    logic [DEN_W:0]     trial;
    logic [NUM_W-1:0]   n_in;
    logic [NUM_W-1:0]   q_in;
    logic [DEN_W-1:0]   r_in;
    logic               ge;
    for (int k = 0; k < NUM_W; k++) begin
      for (int l = 0; l < LANES; l++) begin
        n_in  = (k == 0) ? num[l] : num_r[k-1][l];
        q_in  = (k == 0) ? '0 : quo_r[k-1][l];
        r_in  = (k == 0) ? '0 : rem_r[k-1][l];
        trial = {r_in, n_in[NUM_W-1-k]};
        ge    = (trial >= {1'b0, den[l]});
        rem_next[k][l] = ge ? DEN_W'(trial - {1'b0, den[l]}) : trial[DEN_W-1:0];
        quo_next[k][l] = {q_in[NUM_W-2:0], ge};
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NUM_W; k++) begin
      if (rst) begin
        valid_r[k] <= 1'b0;
      end else if (en) begin
        valid_r[k] <= (k == 0) ? in_valid : valid_r[k-1];
      end
      if (en) begin
        side_r[k] <= (k == 0) ? side_in : side_r[k-1];
        num_r[k]  <= (k == 0) ? num : num_r[k-1];
        quo_r[k]  <= quo_next[k];
        rem_r[k]  <= rem_next[k];
      end
    end
  end

  assign out_valid = valid_r[NUM_W-1];
  assign quo       = quo_r[NUM_W-1];
  assign side_out  = side_r[NUM_W-1];

endmodule

### src/bsa_front.sv
// Front end: accepts requests, detects the early exits and forms the scaled step numerator.
`timescale 1ns / 1ps

module bsa_front #(
  parameter int  VALUE_BITS = bsa_pkg::VALUE_BITS_DEF,
  parameter type item_t = bsa_pkg::item_t
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  output logic                          item_stall,
  input  logic [1:0]                    operation,
  input  logic [VALUE_BITS-1:0]         current_value,
  input  logic [VALUE_BITS-1:0]         value_min,
  input  logic [VALUE_BITS-1:0]         value_max,
  input  logic [bsa_pkg::STEP_BITS-1:0] step_eff,
  input  logic                          queue_full,
  output logic                          push,
  output item_t                         item
);

  localparam int A_W = VALUE_BITS + 2;
  localparam int PROD_W = VALUE_BITS + 8;

  logic          held;
  logic          accept;
  item_t         item_next;
  bsa_pkg::op_t  op;
  logic signed [A_W-1:0] a;
  logic [A_W-1:0] a_abs;

  assign item_stall = held && queue_full;
  assign accept     = item_valid && !item_stall;
  assign push       = held && !queue_full;

  always_comb begin
    op = bsa_pkg::op_t'(operation);
    if (op == bsa_pkg::OP_INC) begin
      a = $signed({2'b00, value_max}) - $signed({2'b00, current_value}) - $signed(A_W'(1));
    end else begin
      a = $signed({2'b00, current_value}) - $signed(A_W'(1));
    end
    a_abs = a[A_W-1] ? A_W'(-a) : A_W'(a);

    item_next.op    = op;
    item_next.cur   = current_value;
    item_next.a_neg = a[A_W-1];
    // Step index numerator magnitude; the sign rides along for truncation toward zero.
    item_next.a_prod = PROD_W'(a_abs[VALUE_BITS:0]) * PROD_W'(step_eff);
    item_next.early  = (value_max == '0)
                    || (op == bsa_pkg::OP_INC && current_value == value_max)
                    || (op == bsa_pkg::OP_DEC && current_value == value_min);
    item_next.early_val = (value_max != '0 && op == bsa_pkg::OP_INC) ? value_max : value_min;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (accept) begin
      held <= 1'b1;
    end else if (push) begin
      held <= 1'b0;
    end
    if (accept) begin
      item <= item_next;
    end
  end

endmodule

### src/bsa_fifo.sv
// Short flop-based queue that decouples the front end from the arithmetic pipeline.
`timescale 1ns / 1ps

module bsa_fifo #(
  parameter int  DEPTH = bsa_pkg::QUEUE_DEPTH,
  parameter type item_t = bsa_pkg::item_t
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t wr_data,
  input  logic  pop,
  output item_t rd_data,
  output logic  full,
  output logic  empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  item_t            entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign rd_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
    if (push) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("queue read while empty");
  a_ptr_match: assert property (@(posedge clk) disable iff (rst)
    (full || empty) |-> wr_ptr == rd_ptr)
    else $error("queue pointers disagree with fill count");

endmodule

### src/bsa_back.sv
// Back end: divider pipeline that computes step index, step values, percentages and the result.
`timescale 1ns / 1ps

module bsa_back #(
  parameter int  VALUE_BITS = bsa_pkg::VALUE_BITS_DEF,
  parameter type item_t = bsa_pkg::item_t
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [VALUE_BITS-1:0]         value_min,
  input  logic [VALUE_BITS-1:0]         value_max,
  input  logic [bsa_pkg::STEP_BITS-1:0] step_eff,
  input  logic                          queue_empty,
  input  item_t                         queue_item,
  output logic                          pop,
  output logic                          result_valid,
  input  logic                          result_stall,
  output logic [VALUE_BITS-1:0]         new_value
);

  localparam int VB    = VALUE_BITS;
  localparam int M_W   = VB + 8;
  localparam int S_W   = VB + 10;
  localparam int P_W   = S_W + VB + 2;
  localparam int SB    = bsa_pkg::STEP_BITS;
  localparam int DB_W  = SB + 1;

  // The fine result divides by the percent scale as 4 * QTR: a shift, then a
  // reciprocal multiplication by QTR that is exact over the operand's range.
  localparam int QTR   = bsa_pkg::PCT_SCALE / 4;
  localparam int QTR_B = $clog2(QTR);
  localparam int FR_W  = $clog2(bsa_pkg::PCT_SCALE);
  localparam int FQ_W  = VB + 2;
  localparam int FRH_W = VB + 7;
  localparam int PQ_W  = 2 * VB + 2;
  localparam int FS_W  = PQ_W + 1;
  localparam int RK1   = M_W - 2 + QTR_B;
  localparam int RK2   = FRH_W - 2 + QTR_B;
  localparam int R1_W  = (M_W - 2) + (RK1 - 4);
  localparam int R2_W  = (FRH_W - 2) + (RK2 - 4);
  localparam longint unsigned RM1 = ((64'd1 << RK1) + 64'(QTR - 1)) / 64'(QTR);
  localparam longint unsigned RM2 = ((64'd1 << RK2) + 64'(QTR - 1)) / 64'(QTR);

  typedef struct packed {
    bsa_pkg::op_t    op;
    logic            early;
    logic [VB-1:0]   early_val;
    logic            a_neg;
  } side_a_t;

  typedef struct packed {
    bsa_pkg::op_t    op;
    logic            early;
    logic [VB-1:0]   early_val;
    logic            pz;
    logic [M_W-1:0]  pv;
    logic            neg0;
    logic            neg1;
    logic [PQ_W-1:0] pq;
    logic [FRH_W-1:0] frh;
  } side_b_t;

  typedef struct packed {
    bsa_pkg::op_t    op;
    logic            early;
    logic [VB-1:0]   early_val;
    logic [M_W-1:0]  pv;
    logic [VB-1:0]   c0;
    logic [VB-1:0]   c1;
    logic [VB-1:0]   rf;
  } side_c_t;

  function automatic logic [VB-1:0] clamp_q(input logic [P_W-1:0] q,
                                            input logic [VB-1:0] lo,
                                            input logic [VB-1:0] hi);
    logic [VB-1:0] x;
    x = (q > P_W'(hi)) ? hi : q[VB-1:0];
    return (x < lo) ? lo : x;
  endfunction

  logic en;
  assign en  = !result_valid || !result_stall;
  assign pop = en && !queue_empty;

  // Phase A: step index quotient and percentage of the present value.
  logic [1:0][M_W-1:0]  a_num;
  logic [1:0][VB:0]     a_den;
  logic [1:0][M_W-1:0]  a_quo;
  side_a_t              a_side_in;
  side_a_t              a_side;
  logic                 a_valid;

  assign a_num[0] = queue_item.a_prod;
  assign a_num[1] = M_W'(queue_item.cur) * M_W'(bsa_pkg::PCT_SCALE_X2) + M_W'(value_max);
  assign a_den[0] = {1'b0, value_max};
  assign a_den[1] = {value_max, 1'b0};
  assign a_side_in = '{op: queue_item.op, early: queue_item.early,
                       early_val: queue_item.early_val, a_neg: queue_item.a_neg};

  bsa_divpipe #(.NUM_W(M_W), .DEN_W(VB + 1), .LANES(2), .side_t(side_a_t)) u_div_a (
    .clk(clk), .rst(rst), .en(en), .in_valid(!queue_empty),
    .num(a_num), .den(a_den), .side_in(a_side_in),
    .out_valid(a_valid), .quo(a_quo), .side_out(a_side)
  );

  // Stage B1: signed step indexes and the shifted percentage.
  logic                    b1_valid;
  logic signed [S_W-1:0]   b1_s0;
  logic signed [S_W-1:0]   b1_s1;
  logic [M_W-1:0]          b1_f;
  logic [M_W-1:0]          b1_pv;
  side_a_t                 b1_side;
  logic signed [S_W-1:0]   qs;
  logic signed [S_W-1:0]   s0_next;

  always_comb begin
    qs = a_side.a_neg ? -$signed(S_W'(a_quo[0])) : $signed(S_W'(a_quo[0]));
    s0_next = (a_side.op == bsa_pkg::OP_INC) ? $signed(S_W'(step_eff)) - qs : qs;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_valid <= 1'b0;
    end else if (en) begin
      b1_valid <= a_valid;
    end
    if (en) begin
      b1_s0   <= s0_next;
      b1_s1   <= (a_side.op == bsa_pkg::OP_INC) ? s0_next + $signed(S_W'(1))
                                                : s0_next - $signed(S_W'(1));
      b1_f    <= (a_side.op == bsa_pkg::OP_INC_FINE) ? a_quo[1] + M_W'(1)
                                                     : a_quo[1] - M_W'(1);
      b1_pv   <= a_quo[1];
      b1_side <= a_side;
    end
  end

  // Stage B2: products with the maximum, and the shifted percentage split by the scale.
  logic                      b2_valid;
  logic signed [S_W+VB:0]    b2_p0;
  logic signed [S_W+VB:0]    b2_p1;
  logic [M_W-1:0]            b2_f;
  logic [FQ_W-1:0]           b2_fq;
  logic [M_W-1:0]            b2_pv;
  side_a_t                   b2_side;
  logic [R1_W-1:0]           fq_prod;

  assign fq_prod = R1_W'(b1_f[M_W-1:2]) * R1_W'(RM1);

  always_ff @(posedge clk) begin
    if (rst) begin
      b2_valid <= 1'b0;
    end else if (en) begin
      b2_valid <= b1_valid;
    end
    if (en) begin
      b2_p0   <= (S_W+VB+1)'(b1_s0) * (S_W+VB+1)'($signed({1'b0, value_max}));
      b2_p1   <= (S_W+VB+1)'(b1_s1) * (S_W+VB+1)'($signed({1'b0, value_max}));
      b2_f    <= b1_f;
      b2_fq   <= fq_prod[R1_W-1:RK1];
      b2_pv   <= b1_pv;
      b2_side <= b1_side;
    end
  end

  // Phase B: rounded step values for both candidates; the fine result's partial
  // products ride alongside.
  logic signed [P_W-1:0]    n0;
  logic signed [P_W-1:0]    n1;
  logic [M_W-1:0]           fr_full;
  logic [1:0][P_W-1:0]      b_num;
  logic [1:0][DB_W-1:0]     b_den;
  logic [1:0][P_W-1:0]      b_quo;
  side_b_t                  b_side_in;
  side_b_t                  b_side;
  logic                     b_valid;

  always_comb begin
    n0 = ($signed(P_W'(b2_p0)) <<< 1) + $signed(P_W'(step_eff));
    n1 = ($signed(P_W'(b2_p1)) <<< 1) + $signed(P_W'(step_eff));
    // A negative step value clamps to the minimum, so its quotient is never needed.
    b_num[0] = n0[P_W-1] ? '0 : P_W'(n0);
    b_num[1] = n1[P_W-1] ? '0 : P_W'(n1);
    b_den[0] = {step_eff, 1'b0};
    b_den[1] = {step_eff, 1'b0};
    // Remainder of the shifted percentage modulo the scale.
    fr_full = b2_f - M_W'(b2_fq) * M_W'(bsa_pkg::PCT_SCALE);
    b_side_in = '{op: b2_side.op, early: b2_side.early, early_val: b2_side.early_val,
                  pz: (b2_pv == '0), pv: b2_pv, neg0: n0[P_W-1], neg1: n1[P_W-1],
                  pq: PQ_W'(b2_fq) * PQ_W'(value_max),
                  frh: FRH_W'(fr_full[FR_W-1:0]) * FRH_W'(value_max)
                       + FRH_W'(bsa_pkg::PCT_SCALE / 2)};
  end

  bsa_divpipe #(.NUM_W(P_W), .DEN_W(DB_W), .LANES(2), .side_t(side_b_t)) u_div_b (
    .clk(clk), .rst(rst), .en(en), .in_valid(b2_valid),
    .num(b_num), .den(b_den), .side_in(b_side_in),
    .out_valid(b_valid), .quo(b_quo), .side_out(b_side)
  );

  // Stage C1: clamp the step values and finish the fine result.
  logic              c1_valid;
  side_c_t           c1;
  side_c_t           c1_next;
  logic [R2_W-1:0]   rq_prod;
  logic [FS_W-1:0]   fine;

  always_comb begin
    rq_prod = R2_W'(b_side.frh[FRH_W-1:2]) * R2_W'(RM2);
    fine    = FS_W'(b_side.pq) + FS_W'(rq_prod[R2_W-1:RK2]);
    c1_next.op        = b_side.op;
    c1_next.early     = b_side.early;
    c1_next.early_val = b_side.early_val;
    c1_next.pv        = b_side.pv;
    c1_next.c0 = b_side.neg0 ? value_min : clamp_q(b_quo[0], value_min, value_max);
    c1_next.c1 = b_side.neg1 ? value_min : clamp_q(b_quo[1], value_min, value_max);
    if (b_side.op == bsa_pkg::OP_INC_FINE) begin
      c1_next.rf = (fine > FS_W'(value_max)) ? value_max : fine[VB-1:0];
    end else begin
      c1_next.rf = (b_side.pz || fine < FS_W'(value_min)) ? value_min : fine[VB-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c1_valid <= 1'b0;
    end else if (en) begin
      c1_valid <= b_valid;
    end
    if (en) begin
      c1 <= c1_next;
    end
  end

  // Phase C: percentage of the nearer step value.
  logic [0:0][M_W-1:0]  c_num;
  logic [0:0][VB:0]     c_den;
  logic [0:0][M_W-1:0]  c_quo;
  side_c_t              c_side;
  logic                 c_valid;

  assign c_num[0] = M_W'(c1.c0) * M_W'(bsa_pkg::PCT_SCALE_X2) + M_W'(value_max);
  assign c_den[0] = {value_max, 1'b0};

  bsa_divpipe #(.NUM_W(M_W), .DEN_W(VB + 1), .LANES(1), .side_t(side_c_t)) u_div_c (
    .clk(clk), .rst(rst), .en(en), .in_valid(c1_valid),
    .num(c_num), .den(c_den), .side_in(c1),
    .out_valid(c_valid), .quo(c_quo), .side_out(c_side)
  );

  // Result selection and output register.
  logic          big;
  logic          use_far;
  logic [VB-1:0] result_next;

  always_comb begin
    big = (value_max > VB'(bsa_pkg::PCT_SCALE));
    if (c_side.op == bsa_pkg::OP_INC) begin
      use_far = big && (c_quo[0] <= c_side.pv);
    end else begin
      use_far = big && (c_quo[0] >= c_side.pv);
    end
    if (c_side.early) begin
      result_next = c_side.early_val;
    end else if (c_side.op == bsa_pkg::OP_INC_FINE || c_side.op == bsa_pkg::OP_DEC_FINE) begin
      result_next = c_side.rf;
    end else begin
      result_next = use_far ? c_side.c1 : c_side.c0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (en) begin
      result_valid <= c_valid;
    end
    if (en && c_valid) begin
      new_value <= result_next;
    end
  end

endmodule

### src/brightness_step_adjuster_core.sv
// Top level of the brightness step adjuster: configuration registers, front end, queue, back end.
`timescale 1ns / 1ps
//
// Channel   Handshake                 Payload
// request   item_valid / item_stall   operation, current_value
// result    result_valid / result_stall  new_value
// config    cfg_write                 cfg_index, cfg_data
//
// A request is accepted every cycle while nothing downstream stalls; each one yields one result.
// Three bit-serial divider pipelines compute step index, step values and the percentage check.
// Reset is synchronous and clears only control state; no clearing pass is needed.
// A result stall freezes the divider pipeline, while the front register and a four-entry
// queue keep taking requests until they fill.

module brightness_step_adjuster_core #(
  parameter int VALUE_BITS = bsa_pkg::VALUE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   item_valid,
  output logic                   item_stall,
  input  logic [1:0]             operation,
  input  logic [VALUE_BITS-1:0]  current_value,
  output logic                   result_valid,
  input  logic                   result_stall,
  output logic [VALUE_BITS-1:0]  new_value,
  input  logic                   cfg_write,
  input  logic [1:0]             cfg_index,
  input  logic [VALUE_BITS-1:0]  cfg_data
);

  localparam int SB = bsa_pkg::STEP_BITS;

  // The classified request record at this instance's width.
  typedef struct packed {
    bsa_pkg::op_t            op;
    logic [VALUE_BITS-1:0]   cur;
    logic                    early;
    logic [VALUE_BITS-1:0]   early_val;
    logic                    a_neg;
    logic [VALUE_BITS+7:0]   a_prod;
  } item_t;

  logic [VALUE_BITS-1:0] value_min;
  logic [VALUE_BITS-1:0] value_max;
  logic [SB-1:0]         step_count;
  logic [SB-1:0]         step_eff;

  // Configuration writes; an unknown index is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      value_min  <= '0;
      value_max  <= VALUE_BITS'(bsa_pkg::PCT_SCALE);
      step_count <= SB'(10);
    end else if (cfg_write) begin
      case (cfg_index)
        bsa_pkg::REG_VALUE_MIN:  value_min  <= cfg_data;
        bsa_pkg::REG_VALUE_MAX:  value_max  <= cfg_data;
        bsa_pkg::REG_STEP_COUNT: step_count <= cfg_data[SB-1:0];
        default: ;
      endcase
    end
  end

  // A step count of zero behaves as a single step.
  assign step_eff = (step_count == '0) ? SB'(1) : step_count;

  logic  push;
  logic  pop;
  logic  queue_full;
  logic  queue_empty;
  item_t front_item;
  item_t queue_item;

  bsa_front #(.VALUE_BITS(VALUE_BITS), .item_t(item_t)) u_front (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall),
    .operation(operation), .current_value(current_value),
    .value_min(value_min), .value_max(value_max), .step_eff(step_eff),
    .queue_full(queue_full), .push(push), .item(front_item)
  );

  bsa_fifo #(.DEPTH(bsa_pkg::QUEUE_DEPTH), .item_t(item_t)) u_fifo (
    .clk(clk), .rst(rst),
    .push(push), .wr_data(front_item),
    .pop(pop), .rd_data(queue_item),
    .full(queue_full), .empty(queue_empty)
  );

  bsa_back #(.VALUE_BITS(VALUE_BITS), .item_t(item_t)) u_back (
    .clk(clk), .rst(rst),
    .value_min(value_min), .value_max(value_max), .step_eff(step_eff),
    .queue_empty(queue_empty), .queue_item(queue_item), .pop(pop),
    .result_valid(result_valid), .result_stall(result_stall), .new_value(new_value)
  );

endmodule

### tb/tb_brightness_step_adjuster_core.sv
// Self-checking testbench for the brightness step adjuster: directed, sweep and random requests.
`timescale 1ns / 1ps

module tb_brightness_step_adjuster_core;

  localparam int VB = bsa_pkg::VALUE_BITS_DEF;
  localparam int DRAIN_CYCLES = 150;   // A margin over the pipeline latency.
  localparam int CYCLE_LIMIT = 600000;
  localparam int HOLD_OFF_CYCLES = 400;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          item_valid = 1'b0;
  logic          item_stall;
  logic [1:0]    operation = bsa_pkg::OP_INC;
  logic [VB-1:0] current_value = '0;
  logic          result_valid;
  logic          result_stall = 1'b0;
  logic [VB-1:0] new_value;
  logic          cfg_write = 1'b0;
  logic [1:0]    cfg_index = bsa_pkg::REG_VALUE_MIN;
  logic [VB-1:0] cfg_data = '0;

  brightness_step_adjuster_core DUT (.*);

  always #2 clk = ~clk;

  // Local copy of the configuration registers, updated whenever the testbench writes one.
  longint lim_lo, lim_hi, steps_cfg;

  // Expected new values, oldest first.
  logic [VB-1:0] pending_values[$];

  int     fail_count = 0;
  int     checked_count = 0;
  int     sent_count = 0;
  int     cycle_count = 0;
  int     burst_left = 0;
  int     hold_off_count = 0;
  int     stall_mode = 0;
  int     mode_left = 0;
  logic   hold_off = 1'b0;
  event   hold_off_go;

  // Floor division that rounds toward minus infinity for negative numerators.
  function automatic longint floor_quot(longint num, longint den);
    longint q;
    q = num / den;
    if ((num % den) != 0 && num < 0) q = q - 1;
    return q;
  endfunction

  function automatic longint half_up(longint num, longint den);
    return floor_quot(2 * num + den, 2 * den);
  endfunction

  function automatic longint clamp_level(longint x);
    if (x > lim_hi) x = lim_hi;
    if (x < lim_lo) x = lim_lo;
    return x;
  endfunction

  function automatic longint level_of_step(longint s, longint n);
    return clamp_level(half_up(s * lim_hi, n));
  endfunction

  function automatic longint percent_shown(longint x);
    return half_up(x * bsa_pkg::PCT_SCALE, lim_hi);
  endfunction

  // Computes the adjusted brightness for one request under the current registers.
  function automatic logic [VB-1:0] adjusted_level(bsa_pkg::op_t op, logic [VB-1:0] cur);
    longint v, n, s, r;
    v = cur;
    n = (steps_cfg == 0) ? 1 : steps_cfg;
    if (lim_hi == 0) begin
      r = lim_lo;
    end else begin
      case (op)
        bsa_pkg::OP_INC: begin
          if (v == lim_hi) begin
            r = lim_hi;
          end else begin
            s = n - ((lim_hi - v - 1) * n) / lim_hi;
            // Large ranges: skip a step that would not change the visible percentage.
            if (lim_hi > bsa_pkg::PCT_SCALE &&
                percent_shown(level_of_step(s, n)) <= percent_shown(v)) s = s + 1;
            r = level_of_step(s, n);
          end
        end
        bsa_pkg::OP_DEC: begin
          if (v == lim_lo) begin
            r = lim_lo;
          end else begin
            s = ((v - 1) * n) / lim_hi;
            if (lim_hi > bsa_pkg::PCT_SCALE &&
                percent_shown(level_of_step(s, n)) >= percent_shown(v)) s = s - 1;
            r = level_of_step(s, n);
          end
        end
        bsa_pkg::OP_INC_FINE: begin
          r = half_up(lim_hi * (percent_shown(v) + 1), bsa_pkg::PCT_SCALE);
          if (r > lim_hi) r = lim_hi;
        end
        default: begin
          r = half_up(lim_hi * (percent_shown(v) - 1), bsa_pkg::PCT_SCALE);
          if (r < lim_lo) r = lim_lo;
        end
      endcase
    end
    return r[VB-1:0];
  endfunction

  // Offers one request, with bursts and random gaps, and records its expected result on
  // acceptance. Valid stays high across back-to-back requests.
  task automatic send_request(bsa_pkg::op_t op, logic [VB-1:0] cur);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        item_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    item_valid <= 1'b1;
    operation <= op;
    current_value <= cur;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    pending_values.push_back(adjusted_level(op, cur));
    sent_count++;
  endtask

  task automatic stop_sending();
    item_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
  endtask

  // Waits until every expected result is back and the pipeline has emptied.
  task automatic drain();
    stop_sending();
    while (pending_values.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Writes one register while the block is idle and mirrors it locally.
  task automatic write_reg(logic [1:0] idx, logic [VB-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      bsa_pkg::REG_VALUE_MIN:  lim_lo = data;
      bsa_pkg::REG_VALUE_MAX:  lim_hi = data;
      bsa_pkg::REG_STEP_COUNT: steps_cfg = data[bsa_pkg::STEP_BITS-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic configure(longint lo, longint hi, longint n);
    drain();
    write_reg(bsa_pkg::REG_VALUE_MIN, lo[VB-1:0]);
    write_reg(bsa_pkg::REG_VALUE_MAX, hi[VB-1:0]);
    write_reg(bsa_pkg::REG_STEP_COUNT, n[VB-1:0]);
  endtask

  // Picks a brightness value: mostly inside the range, sometimes anywhere in the field.
  function automatic logic [VB-1:0] pick_level();
    int sel;
    sel = $urandom_range(0, 19);
    if (sel == 0) return VB'($urandom());
    if (sel == 1) return lim_lo[VB-1:0];
    if (sel == 2) return lim_hi[VB-1:0];
    if (lim_lo > lim_hi) return VB'($urandom());
    return VB'($urandom_range(int'(lim_hi), int'(lim_lo)));
  endfunction

  // Directed: the reset settings, both ends of the range, every operation and values
  // outside the range.
  task automatic test_directed_defaults();
    bsa_pkg::op_t op;
    for (int k = 0; k < 4; k++) begin
      op = bsa_pkg::op_t'(k);
      send_request(op, 20'd0);
      send_request(op, 20'd100);
      send_request(op, 20'd55);
      send_request(op, 20'hFFFFF);
    end
    send_request(bsa_pkg::OP_INC, 20'd99);
    send_request(bsa_pkg::OP_DEC, 20'd1);
    send_request(bsa_pkg::OP_INC_FINE, 20'd101);
    send_request(bsa_pkg::OP_DEC_FINE, 20'h5AAAA);
  endtask

  // Register sweep with extremes: a tiny range, the widest range with one and a hundred
  // steps, a raised minimum, and a minimum above the maximum.
  task automatic test_register_extremes();
    longint cfgs[7][3] = '{
      '{0, 1, 1}, '{0, 1048575, 1}, '{0, 1048575, 100}, '{1000, 250000, 7},
      '{1048575, 1048575, 100}, '{500, 200, 3}, '{0, 101, 100}};
    for (int c = 0; c < 7; c++) begin
      configure(cfgs[c][0], cfgs[c][1], cfgs[c][2]);
      for (int k = 0; k < 4; k++) begin
        send_request(bsa_pkg::op_t'(k), lim_lo[VB-1:0]);
        send_request(bsa_pkg::op_t'(k), lim_hi[VB-1:0]);
        send_request(bsa_pkg::op_t'(k), pick_level());
      end
    end
  endtask

  // Random requests under a series of random settings.
  task automatic test_random_requests();
    longint hi, lo;
    for (int phase = 0; phase < 12; phase++) begin
      case ($urandom_range(0, 3))
        0: hi = $urandom_range(150, 1);
        1: hi = $urandom_range(5000, 101);
        default: hi = $urandom_range(1048575, 1);
      endcase
      lo = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(int'(hi), 0);
      configure(lo, hi, $urandom_range(100, 1));
      repeat (75) send_request(bsa_pkg::op_t'($urandom_range(0, 3)), pick_level());
    end
  endtask

  // The result side holds off for a long stretch while requests keep coming, so the
  // pipeline and queue fill and the block stalls its input.
  task automatic test_backpressure();
    configure(0, 4096, 16);
    -> hold_off_go;
    repeat (200) send_request(bsa_pkg::op_t'($urandom_range(0, 3)), pick_level());
  endtask

  // Long hold-off, counted in cycles.
  initial begin
    forever begin
      @(hold_off_go);
      hold_off <= 1'b1;
      for (hold_off_count = 0; hold_off_count < HOLD_OFF_CYCLES; hold_off_count++) begin
        @(posedge clk);
      end
      hold_off <= 1'b0;
    end
  end

  // Result stall pattern: modes of no stall, light and heavy stalling.
  always @(posedge clk) begin
    if (mode_left == 0) begin
      mode_left <= $urandom_range(10, 200);
      stall_mode <= $urandom_range(0, 2);
    end else begin
      mode_left <= mode_left - 1;
    end
    if (hold_off) begin
      result_stall <= 1'b1;
    end else begin
      case (stall_mode)
        0: result_stall <= 1'b0;
        1: result_stall <= ($urandom_range(0, 3) == 0);
        default: result_stall <= ($urandom_range(0, 9) < 7);
      endcase
    end
  end

  // Result checker: each accepted result against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (pending_values.size() == 0) begin
        $error("unexpected result: new_value actual %0d", new_value);
        fail_count++;
      end else begin
        if (new_value !== pending_values[0]) begin
          $error("new_value mismatch: expected %0d actual %0d", pending_values[0], new_value);
          fail_count++;
        end
        void'(pending_values.pop_front());
        checked_count++;
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding",
               cycle_count, pending_values.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    lim_lo = 0;
    lim_hi = 100;
    steps_cfg = 10;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_defaults();
    test_register_extremes();
    test_backpressure();
    test_random_requests();
    drain();
    if (pending_values.size() != 0) begin
      $error("%0d expected results never arrived", pending_values.size());
      fail_count++;
    end
    $display("Sent %0d requests over all four operations, checked %0d results", sent_count,
             checked_count);
    $display("Settings covered range extremes, step counts 1 to 100 and a long result hold-off");
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### files.f
src/bsa_pkg.sv
src/bsa_divpipe.sv
src/bsa_front.sv
src/bsa_fifo.sv
src/bsa_back.sv
src/brightness_step_adjuster_core.sv
tb/tb_brightness_step_adjuster_core.sv
